FILE: src/obme_pkg.sv
// ----------------------------------------------------------------------------
// obme_pkg: shared types and constants
// Payload structs, the classified work entry, fixed-point constants and the
// one-body operator element table.
// ----------------------------------------------------------------------------
package obme_pkg;

  // Field widths
  localparam int unsigned NUM_ORB   = 10;
  localparam int unsigned ORB_IDX_W = 4;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned ACC_W     = 48;

  // Datapath widths
  localparam int unsigned ELEM_W  = 18;               // Q16 element magnitude, up to 2.0
  localparam int unsigned PROD_W  = 2 * COEFF_W;      // |bra| * |ket|
  localparam int unsigned HI_W    = 32;               // high half times element
  localparam int unsigned LO_W    = COEFF_W + ELEM_W; // low half times element
  localparam int unsigned MAG_W   = 33;               // rounded contribution magnitude
  localparam int unsigned QUEUE_DEPTH = 2;

  // Q16 element magnitudes
  localparam logic [ELEM_W-1:0] Q_ONE  = 18'd65536;
  localparam logic [ELEM_W-1:0] Q_HALF = 18'd32768;
  localparam logic [ELEM_W-1:0] Q_TWO  = 18'd131072;
  localparam logic [ELEM_W-1:0] Q_SQ3  = 18'd113512;
  localparam logic [ELEM_W-1:0] Q_HSQ3 = 18'd56756;

  // Element part and sign codes
  localparam logic PART_IMAG = 1'b0;
  localparam logic PART_REAL = 1'b1;
  localparam logic SGN_POS   = 1'b0;
  localparam logic SGN_NEG   = 1'b1;

  // Operator select
  typedef enum logic [FUNC_W-1:0] {
    OP_LX   = 3'd0,
    OP_LY   = 3'd1,
    OP_LZ   = 3'd2,
    OP_LXSX = 3'd3,
    OP_LYSY = 3'd4,
    OP_LZSZ = 3'd5
  } op_e;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [NUM_ORB-1:0]        bra_occ;
    logic signed [COEFF_W-1:0] bra_coeff;
    logic [NUM_ORB-1:0]        ket_occ;
    logic signed [COEFF_W-1:0] ket_coeff;
    logic                      last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum_real;
    logic signed [ACC_W-1:0] sum_imag;
    logic                    saturated;
  } out_item_t;

  // Table entry
  typedef struct packed {
    logic              hit;
    logic              real_sel;
    logic              neg;
    logic [ELEM_W-1:0] mag;
  } elem_t;

  // Classified pair, front to back; mat is zero for a pair that adds nothing
  typedef struct packed {
    logic               real_sel;
    logic               neg;
    logic [ELEM_W-1:0]  mat;
    logic [COEFF_W-1:0] bra_mag;
    logic [COEFF_W-1:0] ket_mag;
    logic               last;
  } work_t;

  localparam elem_t NO_ELEM = '{hit: 1'b0, real_sel: PART_IMAG, neg: SGN_POS, mag: '0};

  function automatic elem_t mk_elem(logic real_sel, logic neg, logic [ELEM_W-1:0] mag);
    elem_t e;
    e.hit      = 1'b1;
    e.real_sel = real_sel;
    e.neg      = neg;
    e.mag      = mag;
    return e;
  endfunction

  // Matrix element for (operator, src, dst); key nibbles are {src, dst}
  function automatic elem_t elem_lookup(logic [FUNC_W-1:0] func,
                                        logic [ORB_IDX_W-1:0] src,
                                        logic [ORB_IDX_W-1:0] dst);
    logic [2*ORB_IDX_W-1:0] key;
    elem_t e;
    key = {src, dst};
    e   = NO_ELEM;
    case (func)
      OP_LX: begin
        case (key)
          8'h04: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h15: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h26: e = mk_elem(PART_IMAG, SGN_POS, Q_SQ3);
          8'h37: e = mk_elem(PART_IMAG, SGN_POS, Q_SQ3);
          8'h28: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h39: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h40: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h51: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h62: e = mk_elem(PART_IMAG, SGN_NEG, Q_SQ3);
          8'h73: e = mk_elem(PART_IMAG, SGN_NEG, Q_SQ3);
          8'h82: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h93: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          default: e = NO_ELEM;
        endcase
      end
      OP_LY: begin
        case (key)
          8'h06: e = mk_elem(PART_IMAG, SGN_NEG, Q_SQ3);
          8'h17: e = mk_elem(PART_IMAG, SGN_NEG, Q_SQ3);
          8'h08: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h19: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h24: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h35: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h42: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h53: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h60: e = mk_elem(PART_IMAG, SGN_POS, Q_SQ3);
          8'h71: e = mk_elem(PART_IMAG, SGN_POS, Q_SQ3);
          8'h80: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h91: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          default: e = NO_ELEM;
        endcase
      end
      OP_LZ: begin
        case (key)
          8'h02: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h13: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h20: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h31: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h48: e = mk_elem(PART_IMAG, SGN_NEG, Q_TWO);
          8'h59: e = mk_elem(PART_IMAG, SGN_NEG, Q_TWO);
          8'h84: e = mk_elem(PART_IMAG, SGN_POS, Q_TWO);
          8'h95: e = mk_elem(PART_IMAG, SGN_POS, Q_TWO);
          default: e = NO_ELEM;
        endcase
      end
      OP_LXSX: begin
        case (key)
          8'h05: e = mk_elem(PART_IMAG, SGN_NEG, Q_HALF);
          8'h14: e = mk_elem(PART_IMAG, SGN_NEG, Q_HALF);
          8'h27: e = mk_elem(PART_IMAG, SGN_POS, Q_HSQ3);
          8'h36: e = mk_elem(PART_IMAG, SGN_POS, Q_HSQ3);
          8'h29: e = mk_elem(PART_IMAG, SGN_POS, Q_HALF);
          8'h38: e = mk_elem(PART_IMAG, SGN_POS, Q_HALF);
          8'h41: e = mk_elem(PART_IMAG, SGN_POS, Q_HALF);
          8'h50: e = mk_elem(PART_IMAG, SGN_POS, Q_HALF);
          8'h63: e = mk_elem(PART_IMAG, SGN_NEG, Q_HSQ3);
          8'h72: e = mk_elem(PART_IMAG, SGN_NEG, Q_HSQ3);
          8'h83: e = mk_elem(PART_IMAG, SGN_NEG, Q_HALF);
          8'h92: e = mk_elem(PART_IMAG, SGN_NEG, Q_HALF);
          default: e = NO_ELEM;
        endcase
      end
      OP_LYSY: begin
        case (key)
          8'h07: e = mk_elem(PART_REAL, SGN_POS, Q_HSQ3);
          8'h09: e = mk_elem(PART_REAL, SGN_NEG, Q_HALF);
          8'h16: e = mk_elem(PART_REAL, SGN_NEG, Q_HSQ3);
          8'h18: e = mk_elem(PART_REAL, SGN_POS, Q_HALF);
          8'h25: e = mk_elem(PART_REAL, SGN_NEG, Q_HALF);
          8'h34: e = mk_elem(PART_REAL, SGN_POS, Q_HALF);
          8'h43: e = mk_elem(PART_REAL, SGN_POS, Q_HALF);
          8'h52: e = mk_elem(PART_REAL, SGN_NEG, Q_HALF);
          8'h61: e = mk_elem(PART_REAL, SGN_NEG, Q_HSQ3);
          8'h70: e = mk_elem(PART_REAL, SGN_POS, Q_HSQ3);
          8'h81: e = mk_elem(PART_REAL, SGN_POS, Q_HALF);
          8'h90: e = mk_elem(PART_REAL, SGN_NEG, Q_HALF);
          default: e = NO_ELEM;
        endcase
      end
      OP_LZSZ: begin
        case (key)
          8'h02: e = mk_elem(PART_IMAG, SGN_POS, Q_HALF);
          8'h13: e = mk_elem(PART_IMAG, SGN_NEG, Q_HALF);
          8'h20: e = mk_elem(PART_IMAG, SGN_NEG, Q_HALF);
          8'h31: e = mk_elem(PART_IMAG, SGN_POS, Q_HALF);
          8'h48: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          8'h59: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h84: e = mk_elem(PART_IMAG, SGN_POS, Q_ONE);
          8'h95: e = mk_elem(PART_IMAG, SGN_NEG, Q_ONE);
          default: e = NO_ELEM;
        endcase
      end
      default: e = NO_ELEM;
    endcase
    return e;
  endfunction

endpackage

FILE: src/obme_front.sv
// ----------------------------------------------------------------------------
// obme_front: pair classifier
// Accepts determinant pairs, detects a single excitation, looks up the
// operator element, folds all signs together and pushes the work entry.
// ----------------------------------------------------------------------------
module obme_front import obme_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output work_t    work_o
);

  logic [NUM_ORB-1:0]   removed, added, between;
  logic                 single;
  logic [ORB_IDX_W-1:0] src, dst;
  elem_t                elem;
  logic                 parity;
  logic                 bra_neg, ket_neg;

  // Handshake: take a pair whenever the queue has room
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Excitation detect
  assign removed = in_data_i.ket_occ & ~in_data_i.bra_occ;
  assign added   = in_data_i.bra_occ & ~in_data_i.ket_occ;
  assign single  = (removed != '0) && ((removed & (removed - NUM_ORB'(1))) == '0) &&
                   (added != '0) && ((added & (added - NUM_ORB'(1))) == '0);

  // Orbital index of each one-hot vector
  always_comb begin
    src = '0;
    dst = '0;
    for (int i = 0; i < NUM_ORB; i++) begin
      if (removed[i]) src = ORB_IDX_W'(i);
      if (added[i])   dst = ORB_IDX_W'(i);
    end
  end

  // Fermi sign: ket occupancy strictly between src and dst
  assign between = ((removed - NUM_ORB'(1)) ^ (added - NUM_ORB'(1))) & ~(removed | added);
  assign parity  = ^(in_data_i.ket_occ & between);

  assign elem = elem_lookup(in_data_i.func, src, dst);

  // Coefficient sign and magnitude
  assign bra_neg = in_data_i.bra_coeff[COEFF_W-1];
  assign ket_neg = in_data_i.ket_coeff[COEFF_W-1];

  always_comb begin
    work_o.real_sel = elem.real_sel;
    work_o.neg      = parity ^ bra_neg ^ ket_neg ^ elem.neg;
    work_o.mat      = (single && elem.hit) ? elem.mag : '0;
    work_o.bra_mag  = bra_neg ? (~in_data_i.bra_coeff + COEFF_W'(1)) : in_data_i.bra_coeff;
    work_o.ket_mag  = ket_neg ? (~in_data_i.ket_coeff + COEFF_W'(1)) : in_data_i.ket_coeff;
    work_o.last     = in_data_i.last_pair;
  end

endmodule

FILE: src/obme_queue.sv
// ----------------------------------------------------------------------------
// obme_queue: work queue
// Short FIFO of classified pairs between the classifier and the datapath.
// ----------------------------------------------------------------------------
module obme_queue import obme_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  input  logic  pop_i,
  output work_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: src/obme_back.sv
// ----------------------------------------------------------------------------
// obme_back: multiply and accumulate datapath
// Coefficient product, scaling by the element with rounding, saturating
// complex accumulation and the result register.
// ----------------------------------------------------------------------------
module obme_back import obme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  work_t     work_i,
  input  logic      avail_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_LIMIT = (MAG_W'(1) << 31) + (MAG_W'(1) << 17);
  localparam logic [LO_W-1:0]  RND_HALF  = LO_W'(32768);

  logic adv;

  // Stage 1: coefficient product
  logic               v1_q;
  logic [PROD_W-1:0]  m1_q;
  logic [ELEM_W-1:0]  mat1_q;
  logic               neg1_q, real1_q, last1_q;

  // Stage 2: partial products with the element
  logic               v2_q;
  logic [HI_W-1:0]    phi_q;
  logic [LO_W-1:0]    plo_q;
  logic               neg2_q, real2_q, last2_q;
  logic [HI_W-1:0]    phi_full;

  // Stage 3: rounded magnitude
  logic               v3_q;
  logic [MAG_W-1:0]   mag3_q;
  logic               neg3_q, real3_q, last3_q;
  logic [LO_W-1:0]    lo_rnd;

  // Accumulators and result
  logic signed [ACC_W-1:0] acc_real_q, acc_real_d, acc_imag_q, acc_imag_d;
  logic signed [ACC_W-1:0] real_new, imag_new, add_res;
  logic signed [ACC_W:0]   acc_ext, mag_ext, sum;
  logic                    sat_q, sat_d, sat_new, ovf;
  logic                    out_valid_q;
  out_item_t               out_data_q;

  // Whole pipeline moves unless a finished result is held up
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = avail_i && adv;

  // High half times element peaks at 2^31, so it fits the high product word
  assign phi_full = HI_W'(m1_q[PROD_W-1:COEFF_W]) * HI_W'(mat1_q);
  assign lo_rnd   = plo_q + RND_HALF;

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q    <= PROD_W'(work_i.bra_mag) * PROD_W'(work_i.ket_mag);
      mat1_q  <= work_i.mat;
      neg1_q  <= work_i.neg;
      real1_q <= work_i.real_sel;
      last1_q <= work_i.last;

      phi_q   <= phi_full;
      plo_q   <= LO_W'(m1_q[COEFF_W-1:0]) * LO_W'(mat1_q);
      neg2_q  <= neg1_q;
      real2_q <= real1_q;
      last2_q <= last1_q;

      mag3_q  <= MAG_W'(phi_q) + MAG_W'(lo_rnd[LO_W-1:16]);
      neg3_q  <= neg2_q;
      real3_q <= real2_q;
      last3_q <= last2_q;
    end
  end

  // Saturating add into the selected accumulator
  always_comb begin
    acc_ext = real3_q ? {acc_real_q[ACC_W-1], acc_real_q} : {acc_imag_q[ACC_W-1], acc_imag_q};
    mag_ext = signed'((ACC_W+1)'(mag3_q));
    sum     = neg3_q ? acc_ext - mag_ext : acc_ext + mag_ext;
    ovf     = (sum[ACC_W] != sum[ACC_W-1]);
    add_res = ovf ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

    real_new = (v3_q && real3_q)  ? add_res : acc_real_q;
    imag_new = (v3_q && !real3_q) ? add_res : acc_imag_q;
    sat_new  = sat_q || (v3_q && ovf);

    acc_real_d = acc_real_q;
    acc_imag_d = acc_imag_q;
    sat_d      = sat_q;
    if (adv && v3_q) begin
      if (last3_q) begin
        acc_real_d = '0;
        acc_imag_d = '0;
        sat_d      = 1'b0;
      end else begin
        acc_real_d = real_new;
        acc_imag_d = imag_new;
        sat_d      = sat_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_real_q  <= '0;
      acc_imag_q  <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_real_q <= acc_real_d;
      acc_imag_q <= acc_imag_d;
      sat_q      <= sat_d;
      if (adv) begin
        out_valid_q <= v3_q && last3_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv && v3_q && last3_q) begin
      out_data_q.sum_real  <= real_new;
      out_data_q.sum_imag  <= imag_new;
      out_data_q.saturated <= sat_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Closing pair empties the accumulators
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v3_q && last3_q |=> acc_real_q == '0 && acc_imag_q == '0 && !sat_q)
    else $error("accumulators not cleared after closing pair");

  // Closing pair lands in the result register
  a_emit_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v3_q && last3_q |=> out_valid_q)
    else $error("closing pair produced no result");

  // Rounded contribution stays within its analytic bound
  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> mag3_q <= MAG_LIMIT)
    else $error("contribution magnitude out of range");

endmodule

FILE: src/one_body_operator_matrix_element.sv
// ----------------------------------------------------------------------------
// one_body_operator_matrix_element: one-body operator matrix element engine
// Takes one bra/ket determinant pair per cycle while the queue has room. A
// pair that differs by a single moved electron picks up the Lx, Ly, Lz,
// LxSx, LySy or LzSz element for that move, scaled by the Fermi sign and both
// coefficients, and adds it to 48-bit saturating complex accumulators; the
// pair marked last emits the sum and clears it. A closing pair passes the
// queue, the product, partial-product and rounding stages and the accumulate
// step before its result appears. A stalled result freezes the datapath and
// the two-entry work queue then fills, after which input is stalled.
// ----------------------------------------------------------------------------
module one_body_operator_matrix_element import obme_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic  push, pop, queue_full, queue_empty;
  work_t work_in, work_out;

  // Classifier
  obme_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .work_o       (work_in)
  );

  // Work queue
  obme_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work_in),
    .pop_i   (pop),
    .data_o  (work_out),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  // Datapath and accumulators
  obme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .work_i      (work_out),
    .avail_i     (!queue_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/tb_one_body_operator_matrix_element.sv
// ----------------------------------------------------------------------------
// tb_one_body_operator_matrix_element: self-checking bench for the one-body
// operator matrix element engine.
// Streams determinant pairs through the input channel and tracks the Slater-
// Condon single-excitation sum in a local predictor. Each emitted sum is
// checked field by field. Covers a directed set of corner cases, long
// back-to-back sums on each accumulator in both directions, and a randomized
// stream with random gaps on the input side and random stalls on the result
// side.
// ----------------------------------------------------------------------------
module tb_one_body_operator_matrix_element import obme_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Q16 element magnitudes
  localparam int ONE  = 65536;
  localparam int HALF = 32768;
  localparam int TWO  = 131072;
  localparam int SQ3  = 113512;
  localparam int HSQ3 = 56756;

  // Operator codes with no operator behind them
  localparam logic [FUNC_W-1:0] FUNC_UNDEF_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNDEF_HI = 3'd7;

  localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN = -(64'sd1 <<< (ACC_W - 1));

  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM   = 400;

  typedef struct packed {
    logic [FUNC_W-1:0]    op;
    logic [ORB_IDX_W-1:0] src;
    logic [ORB_IDX_W-1:0] dst;
    logic                 re;
    int                   val;
  } transition_t;

  // Allowed single-electron moves and their signed Q16 elements
  localparam transition_t ELEMENTS [64] = '{
    '{OP_LX, 0, 4, PART_IMAG, -ONE}, '{OP_LX, 1, 5, PART_IMAG, -ONE},
    '{OP_LX, 2, 6, PART_IMAG, SQ3},  '{OP_LX, 3, 7, PART_IMAG, SQ3},
    '{OP_LX, 2, 8, PART_IMAG, ONE},  '{OP_LX, 3, 9, PART_IMAG, ONE},
    '{OP_LX, 4, 0, PART_IMAG, ONE},  '{OP_LX, 5, 1, PART_IMAG, ONE},
    '{OP_LX, 6, 2, PART_IMAG, -SQ3}, '{OP_LX, 7, 3, PART_IMAG, -SQ3},
    '{OP_LX, 8, 2, PART_IMAG, -ONE}, '{OP_LX, 9, 3, PART_IMAG, -ONE},
    '{OP_LY, 0, 6, PART_IMAG, -SQ3}, '{OP_LY, 1, 7, PART_IMAG, -SQ3},
    '{OP_LY, 0, 8, PART_IMAG, ONE},  '{OP_LY, 1, 9, PART_IMAG, ONE},
    '{OP_LY, 2, 4, PART_IMAG, ONE},  '{OP_LY, 3, 5, PART_IMAG, ONE},
    '{OP_LY, 4, 2, PART_IMAG, -ONE}, '{OP_LY, 5, 3, PART_IMAG, -ONE},
    '{OP_LY, 6, 0, PART_IMAG, SQ3},  '{OP_LY, 7, 1, PART_IMAG, SQ3},
    '{OP_LY, 8, 0, PART_IMAG, -ONE}, '{OP_LY, 9, 1, PART_IMAG, -ONE},
    '{OP_LZ, 0, 2, PART_IMAG, ONE},  '{OP_LZ, 1, 3, PART_IMAG, ONE},
    '{OP_LZ, 2, 0, PART_IMAG, -ONE}, '{OP_LZ, 3, 1, PART_IMAG, -ONE},
    '{OP_LZ, 4, 8, PART_IMAG, -TWO}, '{OP_LZ, 5, 9, PART_IMAG, -TWO},
    '{OP_LZ, 8, 4, PART_IMAG, TWO},  '{OP_LZ, 9, 5, PART_IMAG, TWO},
    '{OP_LXSX, 0, 5, PART_IMAG, -HALF}, '{OP_LXSX, 1, 4, PART_IMAG, -HALF},
    '{OP_LXSX, 2, 7, PART_IMAG, HSQ3},  '{OP_LXSX, 3, 6, PART_IMAG, HSQ3},
    '{OP_LXSX, 2, 9, PART_IMAG, HALF},  '{OP_LXSX, 3, 8, PART_IMAG, HALF},
    '{OP_LXSX, 4, 1, PART_IMAG, HALF},  '{OP_LXSX, 5, 0, PART_IMAG, HALF},
    '{OP_LXSX, 6, 3, PART_IMAG, -HSQ3}, '{OP_LXSX, 7, 2, PART_IMAG, -HSQ3},
    '{OP_LXSX, 8, 3, PART_IMAG, -HALF}, '{OP_LXSX, 9, 2, PART_IMAG, -HALF},
    '{OP_LYSY, 0, 7, PART_REAL, HSQ3},  '{OP_LYSY, 0, 9, PART_REAL, -HALF},
    '{OP_LYSY, 1, 6, PART_REAL, -HSQ3}, '{OP_LYSY, 1, 8, PART_REAL, HALF},
    '{OP_LYSY, 2, 5, PART_REAL, -HALF}, '{OP_LYSY, 3, 4, PART_REAL, HALF},
    '{OP_LYSY, 4, 3, PART_REAL, HALF},  '{OP_LYSY, 5, 2, PART_REAL, -HALF},
    '{OP_LYSY, 6, 1, PART_REAL, -HSQ3}, '{OP_LYSY, 7, 0, PART_REAL, HSQ3},
    '{OP_LYSY, 8, 1, PART_REAL, HALF},  '{OP_LYSY, 9, 0, PART_REAL, -HALF},
    '{OP_LZSZ, 0, 2, PART_IMAG, HALF},  '{OP_LZSZ, 1, 3, PART_IMAG, -HALF},
    '{OP_LZSZ, 2, 0, PART_IMAG, -HALF}, '{OP_LZSZ, 3, 1, PART_IMAG, HALF},
    '{OP_LZSZ, 4, 8, PART_IMAG, -ONE},  '{OP_LZSZ, 5, 9, PART_IMAG, ONE},
    '{OP_LZSZ, 8, 4, PART_IMAG, ONE},   '{OP_LZSZ, 9, 5, PART_IMAG, -ONE}
  };

  // Running matrix element sum and the queue of sums still to come out
  class matrix_element_tracker;
    longint    acc_real;
    longint    acc_imag;
    bit        clamped;
    out_item_t sums_due[$];
    int        mismatches;
    int        pairs_seen;
    int        sums_seen;
    int        clamped_sums;

    function new();
      acc_real = 0;
      acc_imag = 0;
      clamped  = 1'b0;
    endfunction

    // Signed add that clamps to the accumulator range
    function longint clamp_add(longint acc, longint unsigned mag, bit neg);
      longint s;
      s = neg ? acc - longint'(mag) : acc + longint'(mag);
      if (s > ACC_MAX) begin
        s = ACC_MAX;
        clamped = 1'b1;
      end else if (s < ACC_MIN) begin
        s = ACC_MIN;
        clamped = 1'b1;
      end
      return s;
    endfunction

    task note_transfer(in_item_t it);
      logic [NUM_ORB-1:0] removed, added;
      int src, dst, hit, cnt, bc, kc, lo, hi, ev;
      bit neg;
      longint unsigned m, mat, mag;
      out_item_t sum;
      pairs_seen++;
      removed = it.ket_occ & ~it.bra_occ;
      added   = it.bra_occ & ~it.ket_occ;
      hit = -1;
      src = 0;
      dst = 0;
      if ($onehot(removed) && $onehot(added)) begin
        for (int b = 0; b < NUM_ORB; b++) begin
          if (removed[b]) src = b;
          if (added[b]) dst = b;
        end
        for (int k = 0; k < 64; k++)
          if (ELEMENTS[k].op == it.func && ELEMENTS[k].src == src &&
              ELEMENTS[k].dst == dst)
            hit = k;
      end
      if (hit >= 0) begin
        // Fermi sign: ket electrons strictly between the two orbitals
        lo = (src < dst) ? src : dst;
        hi = (src < dst) ? dst : src;
        cnt = 0;
        for (int b = lo + 1; b < hi; b++) cnt += it.ket_occ[b];
        bc = $signed(it.bra_coeff);
        kc = $signed(it.ket_coeff);
        ev = ELEMENTS[hit].val;
        m = longint'(bc < 0 ? -bc : bc) * longint'(kc < 0 ? -kc : kc);
        mat = longint'(ev < 0 ? -ev : ev);
        // round half away from zero on the magnitude
        mag = (m >> 16) * mat + (((m & 64'hFFFF) * mat + 64'd32768) >> 16);
        neg = cnt[0] ^ (bc < 0) ^ (kc < 0) ^ (ev < 0);
        if (mag != 0) begin
          if (ELEMENTS[hit].re == PART_REAL) acc_real = clamp_add(acc_real, mag, neg);
          else acc_imag = clamp_add(acc_imag, mag, neg);
        end
      end
      if (it.last_pair) begin
        sum.sum_real  = acc_real[ACC_W-1:0];
        sum.sum_imag  = acc_imag[ACC_W-1:0];
        sum.saturated = clamped;
        sums_due.push_back(sum);
        acc_real = 0;
        acc_imag = 0;
        clamped  = 1'b0;
      end
    endtask

    task report(string what, longint got, longint want);
      $display("mismatch in sum %0d, %s: got %0d, expected %0d", sums_seen, what, got, want);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      sums_seen++;
      if (sums_due.size() == 0) begin
        report("sum_real of an unexpected result", got.sum_real, 0);
        return;
      end
      want = sums_due.pop_front();
      if (want.saturated) clamped_sums++;
      if (got.sum_real !== want.sum_real) report("sum_real", got.sum_real, want.sum_real);
      if (got.sum_imag !== want.sum_imag) report("sum_imag", got.sum_imag, want.sum_imag);
      if (got.saturated !== want.saturated)
        report("saturated", got.saturated, want.saturated);
    endtask
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  matrix_element_tracker tracker;
  bit idle_on    = 1'b1;
  int stall_left = 0;

  one_body_operator_matrix_element DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side stalls
  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  // Transfer monitors
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) tracker.note_transfer(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_result(out_data_o);
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Pair where one electron moves from src (ket) to dst (bra) over background bg
  function automatic in_item_t excite(logic [FUNC_W-1:0] func, int src, int dst,
                                      logic [NUM_ORB-1:0] bg, int bc, int kc, bit last);
    in_item_t it;
    it.func         = func;
    it.ket_occ      = bg;
    it.ket_occ[src] = 1'b1;
    it.ket_occ[dst] = 1'b0;
    it.bra_occ      = it.ket_occ;
    it.bra_occ[src] = 1'b0;
    it.bra_occ[dst] = 1'b1;
    it.bra_coeff    = 16'(bc);
    it.ket_coeff    = 16'(kc);
    it.last_pair    = last;
    return it;
  endfunction

  function automatic int pick_coeff();
    logic signed [COEFF_W-1:0] raw;
    raw = 16'($urandom);
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return $urandom_range(0, 1) ? 1 : -1;
      default: return raw;
    endcase
  endfunction

  // Mostly table moves with random content, the rest noise
  function automatic in_item_t random_pair();
    in_item_t it;
    int kind, k, s, d;
    kind = $urandom_range(0, 99);
    k = $urandom_range(0, 63);
    s = $urandom_range(0, NUM_ORB - 1);
    d = (s + 1 + $urandom_range(0, NUM_ORB - 2)) % NUM_ORB;
    it = excite(ELEMENTS[k].op, ELEMENTS[k].src, ELEMENTS[k].dst, 10'($urandom),
                pick_coeff(), pick_coeff(), $urandom_range(0, 5) == 0);
    if (kind >= 95) begin
      it = excite(3'($urandom_range(0, 7)), s, d, 10'($urandom),
                  pick_coeff(), pick_coeff(), it.last_pair);
    end else if (kind >= 85) begin
      it.func    = 3'($urandom_range(0, 7));
      it.bra_occ = 10'($urandom);
      it.ket_occ = 10'($urandom);
    end else if (kind >= 80) begin
      it.bra_occ = it.ket_occ;
    end else if (kind >= 75) begin
      it.func = $urandom_range(0, 1) ? FUNC_UNDEF_LO : FUNC_UNDEF_HI;
    end
    return it;
  endfunction

  task automatic send_pair(in_item_t it);
    int gap;
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Long sum that piles up on one accumulator, then backs off
  task automatic long_sum(in_item_t push, in_item_t pull, int n);
    for (int i = 0; i < n; i++) send_pair(push);
    repeat (2) send_pair(pull);
    pull.last_pair = 1'b1;
    send_pair(pull);
  endtask

  initial begin
    in_item_t it;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases
    send_pair(excite(OP_LX, 0, 4, 10'h000, 32767, 32767, 1'b0));
    send_pair(excite(OP_LY, 0, 6, 10'h3FF, -32768, -32768, 1'b0));
    send_pair(excite(OP_LZ, 4, 8, 10'h3FF, -32768, 32767, 1'b0));
    send_pair(excite(OP_LXSX, 2, 7, 10'h0A5, 12345, -20000, 1'b0));
    send_pair(excite(OP_LYSY, 0, 7, 10'h3FF, -32768, -32768, 1'b0));
    send_pair(excite(OP_LZSZ, 9, 5, 10'h000, 1, 1, 1'b0));
    send_pair(excite(OP_LYSY, 9, 0, 10'h2AA, 1, -1, 1'b1));
    send_pair(excite(FUNC_UNDEF_LO, 0, 4, 10'h000, 32767, 32767, 1'b0));
    send_pair(excite(FUNC_UNDEF_HI, 0, 4, 10'h000, 32767, 32767, 1'b0));
    it = excite(OP_LX, 0, 4, 10'h155, 32767, 32767, 1'b0);
    it.bra_occ = it.ket_occ;                       // identical determinants
    send_pair(it);
    it.ket_occ = 10'h003;                          // two electrons moved
    it.bra_occ = 10'h030;
    send_pair(it);
    send_pair(excite(OP_LZ, 0, 4, 10'h000, 32767, 32767, 1'b0));  // not in table
    it.ket_occ = 10'h011;                          // one removed, none added
    it.bra_occ = 10'h001;
    send_pair(it);
    send_pair(excite(OP_LX, 0, 4, 10'h000, 0, -32768, 1'b0));
    it.ket_occ   = 10'h3FF;
    it.bra_occ   = 10'h000;
    it.last_pair = 1'b1;
    send_pair(it);
    send_pair('{func: OP_LX, last_pair: 1'b1, default: '0});     // empty sum
    send_pair(excite(OP_LZ, 8, 4, 10'h3FF, -32768, 32767, 1'b0));
    send_pair(excite(OP_LZSZ, 8, 4, 10'h1FF, 32767, 32767, 1'b1));

    // Long sums on both accumulators in both directions, no idling
    idle_on = 1'b0;
    long_sum(excite(OP_LZ, 4, 8, 10'h000, -32768, -32768, 1'b0),
             excite(OP_LZ, 4, 8, 10'h000, 32767, -32768, 1'b0), 40);
    long_sum(excite(OP_LZ, 4, 8, 10'h000, 32767, -32768, 1'b0),
             excite(OP_LZ, 4, 8, 10'h000, -32768, -32768, 1'b0), 40);
    long_sum(excite(OP_LYSY, 0, 7, 10'h000, -32768, -32768, 1'b0),
             excite(OP_LYSY, 0, 7, 10'h000, 32767, -32768, 1'b0), 40);
    long_sum(excite(OP_LYSY, 0, 7, 10'h000, 32767, -32768, 1'b0),
             excite(OP_LYSY, 0, 7, 10'h000, -32768, -32768, 1'b0), 40);

    // Random stream, idling switched on and off per block
    for (int blk = 0; blk < 4; blk++) begin
      idle_on = (blk % 2 == 0);
      for (int i = 0; i < N_RANDOM / 4; i++) send_pair(random_pair());
    end
    it = random_pair();
    it.last_pair = 1'b1;                           // close the open sum
    send_pair(it);
    in_valid_i <= 1'b0;

    while (tracker.sums_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("transferred %0d pairs, checked %0d sums, %0d of them clamped",
             tracker.pairs_seen, tracker.sums_seen, tracker.clamped_sums);
    $display("all six operators, undefined codes, non-excitations and long sums both ways");
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
